// File: hdl/csgn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csgn_pkg
// shared types, codes and defaults of the sparse group normalizer
// ----------------------------------------------------------------------------
package csgn_pkg;

    localparam int CSGN_MAX_ENTRIES = 1024;
    localparam int CSGN_INDEX_BITS  = 16;
    localparam int VAL_W            = 32;
    localparam int SUM_W            = 48;
    localparam int QUOT_W           = 32;
    localparam int PORT_IDX_W       = 16;

    // function codes carried on the slave tuser
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // status codes carried on the master tuser
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ZERO_SUM  = 2'd1;
    localparam logic [1:0] STAT_NONE_LEFT = 2'd2;
    localparam logic [1:0] STAT_DROPPED   = 2'd3;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_LOAD,
        CO_ROT,
        CO_SORT_EVEN,
        CO_SORT_ODD
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     by_rows;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNROT,
        S_SORT,
        S_READ,
        S_SUM,
        S_DIVGO,
        S_DIV
    } t_state;

endpackage

// File: hdl/csgn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csgn_cell
// one slot of the entry ring: load, rotate and odd-even compare-exchange
// ----------------------------------------------------------------------------
module csgn_cell
    import csgn_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int INDEX_BITS = CSGN_INDEX_BITS,
    parameter int CNT_W      = 11
) (
    input  logic                          i_clk,
    input  t_cell_ctl                     i_ctl,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [2*INDEX_BITS+VAL_W-1:0] i_new,
    input  logic [2*INDEX_BITS+VAL_W-1:0] i_left,
    input  logic [2*INDEX_BITS+VAL_W-1:0] i_right,
    input  logic [2*INDEX_BITS+VAL_W-1:0] i_head,
    input  logic                          i_left_gt,
    output logic [2*INDEX_BITS+VAL_W-1:0] o_entry,
    output logic                          o_gt
);

    localparam int ENT_W = 2*INDEX_BITS + VAL_W;
    localparam int KEY_W = 2*INDEX_BITS;
    localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);
    localparam logic             MY_PAR   = 1'(IDX % 2);

    logic [ENT_W-1:0] r_entry;
    logic [ENT_W-1:0] n_entry;
    logic [KEY_W-1:0] own_key;
    logic [KEY_W-1:0] right_key;
    logic             left_of_pair;
    logic             right_of_pair;
    logic             phase;

    function automatic logic [KEY_W-1:0] key_of(input logic [ENT_W-1:0] e, input logic rows);
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
        row = e[ENT_W-1 -: INDEX_BITS];
        col = e[VAL_W +: INDEX_BITS];
        return rows ? {row, col} : {col, row};
    endfunction

    assign own_key   = key_of(r_entry, i_ctl.by_rows);
    assign right_key = key_of(i_right, i_ctl.by_rows);
    assign o_gt      = own_key > right_key;
    assign o_entry   = r_entry;

    always_comb begin
        phase         = (i_ctl.op == CO_SORT_ODD);
        left_of_pair  = (MY_PAR == phase) && (NEXT_IDX < i_count);
        right_of_pair = (IDX >= 1) && (MY_PAR != phase) && (MY_IDX < i_count);
        n_entry       = r_entry;
        case (i_ctl.op)
            CO_LOAD: begin
                if (MY_IDX == i_count) n_entry = i_new;
            end
            CO_ROT: begin
                // head wraps into the last occupied slot
                if (MY_IDX == i_count - CNT_W'(1)) n_entry = i_head;
                else n_entry = i_right;
            end
            CO_SORT_EVEN, CO_SORT_ODD: begin
                if (left_of_pair && o_gt) n_entry = i_right;
                else if (right_of_pair && i_left_gt) n_entry = i_left;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: hdl/csgn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csgn_div
// restoring divider, one quotient bit per cycle, value * 2^31 / sum
// ----------------------------------------------------------------------------
module csgn_div
    import csgn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [VAL_W-1:0]  i_num,
    input  logic [SUM_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quot;
    logic              r_bit;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SUM_W:0]    trial;
    logic              ge;

    assign trial  = {r_rem, r_bit};
    assign ge     = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // upper quotient bits are zero since value <= sum, so start from value >> 1
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= SUM_W'(i_num >> 1);
            r_bit  <= i_num[0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? SUM_W'(trial - {1'b0, r_den}) : trial[SUM_W-1:0];
            r_bit  <= 1'b0;
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

endmodule

// File: hdl/coo_sparse_group_normalizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_sparse_group_normalizer_core
// sparse entry store with stable sort and per-group normalization on read
// ----------------------------------------------------------------------------
// load: after partial reads the ring first rotates (count - reads done) steps back to store order,
//   then the entry is appended; clear, unused code and a dropped load answer straight from idle
// first read after a load: count odd-even sort phases, then as for any read
// read: none left is answered from the read state, else count ring steps for a group sum at each
//   group's first entry, then the divider for 32 quotient bits when the group sum is nonzero
// one word in flight at a time; synchronous active-low reset empties the store
module coo_sparse_group_normalizer_core
    import csgn_pkg::*;
#(
    parameter int MAX_ENTRIES = CSGN_MAX_ENTRIES,
    parameter int INDEX_BITS  = CSGN_INDEX_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: by_rows
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // row_index[15:0], col_index[31:16], entry_val[63:32]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_row[15:0], out_col[31:16], norm_val[63:32]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast    // last_entry
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = 2*INDEX_BITS + VAL_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    // ring of entry cells
    logic [ENT_W-1:0] ent [MAX_ENTRIES];
    logic             gt  [MAX_ENTRIES];
    t_cell_ctl        cell_ctl;

    // control state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_rp, n_rp;          // read position in sorted order
    logic [CNT_W-1:0]    r_step, n_step;      // sort phase, sum step or unrotate step
    logic                r_prepared, n_prepared;
    logic                r_by_rows;
    logic                r_sorted_rows, n_sorted_rows;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic                r_sum_act, n_sum_act;
    logic [INDEX_BITS-1:0] r_grp, n_grp;
    logic [INDEX_BITS-1:0] r_prev_grp, n_prev_grp;
    logic [ENT_W-1:0]    r_pend, n_pend;

    // output word register
    logic                r_m_valid, n_m_valid;
    logic [63:0]         r_m_data, n_m_data;
    logic [1:0]          r_m_user, n_m_user;
    logic                r_m_last, n_m_last;

    logic                accept;
    logic [ENT_W-1:0]    head;
    logic [INDEX_BITS-1:0] head_row, head_col, head_grp;
    logic [VAL_W-1:0]    head_val;
    logic [SUM_W:0]      sum_add;
    logic                div_start;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic                emit;

    assign head     = ent[0];
    assign head_val = head[VAL_W-1:0];
    assign head_col = head[VAL_W +: INDEX_BITS];
    assign head_row = head[ENT_W-1 -: INDEX_BITS];
    assign head_grp = r_sorted_rows ? head_row : head_col;
    assign sum_add  = {1'b0, r_sum} + (SUM_W+1)'(head_val);

    assign s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            csgn_cell #(
                .IDX        (gi),
                .INDEX_BITS (INDEX_BITS),
                .CNT_W      (CNT_W)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (cell_ctl),
                .i_count   (r_count),
                .i_new     (r_pend),
                .i_left    (ent[(gi == 0) ? 0 : gi - 1]),
                .i_right   (ent[(gi == MAX_ENTRIES - 1) ? gi : gi + 1]),
                .i_head    (head),
                .i_left_gt ((gi == 0) ? 1'b0 : gt[(gi == 0) ? 0 : gi - 1]),
                .o_entry   (ent[gi]),
                .o_gt      (gt[gi])
            );
        end
    endgenerate

    csgn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (head_val),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_rp          = r_rp;
        n_step        = r_step;
        n_prepared    = r_prepared;
        n_sorted_rows = r_sorted_rows;
        n_sum         = r_sum;
        n_sum_act     = r_sum_act;
        n_grp         = r_grp;
        n_prev_grp    = r_prev_grp;
        n_pend        = r_pend;
        cell_ctl.op      = CO_HOLD;
        cell_ctl.by_rows = r_sorted_rows;
        div_start     = 1'b0;
        emit          = 1'b0;
        n_m_data      = r_m_data;
        n_m_user      = r_m_user;
        n_m_last      = r_m_last;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (s_axis_tuser)
                        FUNC_LOAD: begin
                            if (r_count >= MAX_CNT) begin
                                emit     = 1'b1;
                                n_m_data = '0;
                                n_m_user = STAT_DROPPED;
                                n_m_last = 1'b0;
                            end else begin
                                n_pend  = {INDEX_BITS'(s_axis_tdata[15:0]),
                                           INDEX_BITS'(s_axis_tdata[31:16]),
                                           s_axis_tdata[63:32]};
                                // ring must be back in store order before appending
                                n_step  = (r_rp == '0) ? r_count : r_rp;
                                n_state = S_UNROT;
                            end
                        end
                        FUNC_READ: begin
                            if (!r_prepared) begin
                                n_sorted_rows = r_by_rows;
                                n_step        = '0;
                                n_state       = S_SORT;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_count    = '0;
                            n_rp       = '0;
                            n_prepared = 1'b0;
                            n_sum      = '0;
                            emit       = 1'b1;
                            n_m_data   = '0;
                            n_m_user   = STAT_OK;
                            n_m_last   = 1'b0;
                        end
                        default: begin
                            emit     = 1'b1;
                            n_m_data = '0;
                            n_m_user = STAT_OK;
                            n_m_last = 1'b0;
                        end
                    endcase
                end
            end
            S_UNROT: begin
                if (r_step == r_count) begin
                    cell_ctl.op = CO_LOAD;
                    n_count     = r_count + CNT_W'(1);
                    n_prepared  = 1'b0;
                    n_rp        = '0;
                    emit        = 1'b1;
                    n_m_data    = '0;
                    n_m_user    = STAT_OK;
                    n_m_last    = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    cell_ctl.op = CO_ROT;
                    n_step      = r_step + CNT_W'(1);
                end
            end
            S_SORT: begin
                // odd-even transposition: count phases order count entries
                if (r_step >= r_count) begin
                    n_prepared = 1'b1;
                    n_rp       = '0;
                    n_state    = S_READ;
                end else begin
                    cell_ctl.op = r_step[0] ? CO_SORT_ODD : CO_SORT_EVEN;
                    n_step      = r_step + CNT_W'(1);
                end
            end
            S_READ: begin
                if (r_rp >= r_count) begin
                    emit     = 1'b1;
                    n_m_data = '0;
                    n_m_user = STAT_NONE_LEFT;
                    n_m_last = 1'b0;
                    n_state  = S_IDLE;
                end else if (r_rp == '0 || head_grp != r_prev_grp) begin
                    n_grp     = head_grp;
                    n_sum     = '0;
                    n_sum_act = 1'b1;
                    n_step    = '0;
                    n_state   = S_SUM;
                end else begin
                    n_state = S_DIVGO;
                end
            end
            S_SUM: begin
                // one full turn of the ring, adding the run that starts at the head
                cell_ctl.op = CO_ROT;
                if (r_sum_act && (({1'b0, r_rp} + {1'b0, r_step}) < {1'b0, r_count})
                        && head_grp == r_grp) begin
                    n_sum = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
                end else begin
                    n_sum_act = 1'b0;
                end
                n_step = r_step + CNT_W'(1);
                if (r_step == r_count - CNT_W'(1)) n_state = S_DIVGO;
            end
            S_DIVGO: begin
                if (r_sum == '0) begin
                    cell_ctl.op = CO_ROT;
                    emit        = 1'b1;
                    n_m_data    = {32'd0, PORT_IDX_W'(head_col), PORT_IDX_W'(head_row)};
                    n_m_user    = STAT_ZERO_SUM;
                    n_m_last    = (r_rp + CNT_W'(1)) == r_count;
                    n_rp        = r_rp + CNT_W'(1);
                    n_prev_grp  = head_grp;
                    n_state     = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    cell_ctl.op = CO_ROT;
                    emit        = 1'b1;
                    n_m_data    = {div_quot, PORT_IDX_W'(head_col), PORT_IDX_W'(head_row)};
                    n_m_user    = STAT_OK;
                    n_m_last    = (r_rp + CNT_W'(1)) == r_count;
                    n_rp        = r_rp + CNT_W'(1);
                    n_prev_grp  = head_grp;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (emit) n_m_valid = 1'b1;
        else if (m_axis_tready) n_m_valid = 1'b0;
        else n_m_valid = r_m_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_rp          <= '0;
            r_step        <= '0;
            r_prepared    <= 1'b0;
            r_by_rows     <= 1'b0;
            r_sorted_rows <= 1'b0;
            r_sum         <= '0;
            r_sum_act     <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_rp          <= n_rp;
            r_step        <= n_step;
            r_prepared    <= n_prepared;
            r_sorted_rows <= n_sorted_rows;
            r_sum         <= n_sum;
            r_sum_act     <= n_sum_act;
            r_m_valid     <= n_m_valid;
            if (i_cfg_we) r_by_rows <= i_cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_grp      <= n_grp;
        r_prev_grp <= n_prev_grp;
        r_pend     <= n_pend;
        r_m_data   <= n_m_data;
        r_m_user   <= n_m_user;
        r_m_last   <= n_m_last;
    end

endmodule

// File: hdl/csgn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csgn_checker
// port-level checks of the sparse group normalizer
// ----------------------------------------------------------------------------
module csgn_checker
    import csgn_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_none_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STAT_NONE_LEFT |-> m_axis_tdata == '0 && !m_axis_tlast)
        else $error("empty read carries data");

    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STAT_ZERO_SUM |-> m_axis_tdata[63:32] == '0)
        else $error("zero group sum with nonzero value");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[63] && m_axis_tdata[62:32] != '0))
        else $error("normalized value above one");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == STAT_OK || m_axis_tuser == STAT_ZERO_SUM)
        else $error("last flag on a word that is not a read");

endmodule

bind coo_sparse_group_normalizer_core csgn_checker u_csgn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: test/coo_sparse_group_normalizer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_sparse_group_normalizer_core_test
// self-checking bench: loads, reads and clears sparse entries through the
// stream ports in both grouping modes and compares every returned word with
// a directed expectation or an in-bench sorter and normalizer, under several
// sender and receiver idling patterns
// ----------------------------------------------------------------------------
module coo_sparse_group_normalizer_core_test;
    import csgn_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RANDOM_ITEMS   = 40;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [15:0] row;
        logic [15:0] col;
        logic [31:0] norm;
        logic [1:0]  stat;
        logic        last;
    } t_norm_word;

    typedef struct {
        logic [1:0]  func;
        logic [15:0] row;
        logic [15:0] col;
        logic [31:0] val;
        bit          typed;
        t_norm_word  want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    coo_sparse_group_normalizer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // bench copy of the block state
    logic [15:0] st_row [CSGN_MAX_ENTRIES];
    logic [15:0] st_col [CSGN_MAX_ENTRIES];
    logic [31:0] st_val [CSGN_MAX_ENTRIES];
    int          st_count;
    int          st_rpos;
    bit          st_sorted;
    logic [47:0] st_gsum;
    bit          cfg_by_rows;
    bit          sort_by_rows;

    t_norm_word  pending_words[$];
    int          mismatches;
    int          words_seen;
    int          items_sent;
    int          drops_seen;
    int          zero_sums_seen;
    int          idle_pct;
    int          stall_pct;

    function automatic logic [31:0] sort_key(int i);
        return sort_by_rows ? {st_row[i], st_col[i]} : {st_col[i], st_row[i]};
    endfunction

    function automatic logic [15:0] group_id(int i);
        return sort_by_rows ? st_row[i] : st_col[i];
    endfunction

    // stable insertion sort in the latched grouping mode
    task automatic sort_store();
        logic [15:0] tr, tc;
        logic [31:0] tv, k;
        int j;
        sort_by_rows = cfg_by_rows;
        for (int i = 1; i < st_count; i++) begin
            tr = st_row[i]; tc = st_col[i]; tv = st_val[i];
            k = sort_by_rows ? {tr, tc} : {tc, tr};
            j = i;
            while (j > 0 && sort_key(j - 1) > k) begin
                st_row[j] = st_row[j-1]; st_col[j] = st_col[j-1]; st_val[j] = st_val[j-1];
                j--;
            end
            st_row[j] = tr; st_col[j] = tc; st_val[j] = tv;
        end
        st_sorted = 1'b1;
        st_rpos = 0;
    endtask

    task automatic normalize_step(input logic [1:0] func, input logic [15:0] row,
                                  input logic [15:0] col, input logic [31:0] val,
                                  output t_norm_word w);
        logic [63:0] acc, quot;
        int p;
        w = '{16'd0, 16'd0, 32'd0, STAT_OK, 1'b0};
        if (func == FUNC_LOAD) begin
            if (st_count >= CSGN_MAX_ENTRIES) begin
                w.stat = STAT_DROPPED;
            end else begin
                st_row[st_count] = row; st_col[st_count] = col; st_val[st_count] = val;
                st_count++;
                st_sorted = 1'b0;
                st_rpos = 0;
            end
        end else if (func == FUNC_READ) begin
            if (!st_sorted) sort_store();
            if (st_rpos >= st_count) begin
                w.stat = STAT_NONE_LEFT;
            end else begin
                p = st_rpos;
                // new group: sum forward with saturation at 48 bits
                if (p == 0 || group_id(p - 1) != group_id(p)) begin
                    acc = '0;
                    for (int i = p; i < st_count && group_id(i) == group_id(p); i++) begin
                        acc += 64'(st_val[i]);
                        if (acc > 64'hFFFF_FFFF_FFFF) acc = 64'hFFFF_FFFF_FFFF;
                    end
                    st_gsum = acc[47:0];
                end
                w.row = st_row[p];
                w.col = st_col[p];
                if (st_gsum == '0) begin
                    w.stat = STAT_ZERO_SUM;
                end else begin
                    quot = {1'b0, st_val[p], 31'd0} / {16'd0, st_gsum};
                    if (quot > 64'h8000_0000) quot = 64'h8000_0000;
                    w.norm = quot[31:0];
                end
                st_rpos = p + 1;
                w.last = (st_rpos == st_count);
            end
        end else if (func == FUNC_CLEAR) begin
            st_count = 0;
            st_rpos = 0;
            st_sorted = 1'b0;
            st_gsum = '0;
        end
    endtask

    // drive one word at the falling edge and hold it until the handshake
    task automatic send_word(input logic [1:0] func, input logic [15:0] row,
                             input logic [15:0] col, input logic [31:0] val,
                             input bit typed, input t_norm_word want);
        t_norm_word w;
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = {val, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        normalize_step(func, row, col, val, w);
        if (typed) w = want;
        pending_words.insert(pending_words.size(), w);
        items_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_plain(input logic [1:0] func, input logic [15:0] row,
                              input logic [15:0] col, input logic [31:0] val);
        send_word(func, row, col, val, 1'b0, '{16'd0, 16'd0, 32'd0, STAT_OK, 1'b0});
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // register writes only while nothing is in flight
    task automatic write_by_rows(input bit v);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_by_rows = v;
    endtask

    function automatic logic [31:0] pick_val();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 32'd0;
        if (r < 20) return 32'hFFFF_FFFF;
        if (r < 35) return $urandom_range(1, 8);
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_index(bit wide);
        return wide ? 16'($urandom) : 16'($urandom_range(0, 3));
    endfunction

    // result checker: oldest expectation against every accepted word
    always @(posedge i_clk) begin
        t_norm_word e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (m_axis_tuser == STAT_DROPPED) drops_seen++;
            if (m_axis_tuser == STAT_ZERO_SUM) zero_sums_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h user %h", m_axis_tdata,
                                               m_axis_tuser);
            end else begin
                e = pending_words.pop_front();
                if (m_axis_tdata[15:0] !== e.row || m_axis_tdata[31:16] !== e.col ||
                    m_axis_tdata[63:32] !== e.norm || m_axis_tuser !== e.stat ||
                    m_axis_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: exp row %h col %h norm %h stat %0d last %0d,",
                               e.row, e.col, e.norm, e.stat, e.last);
                        $display(" got row %h col %h norm %h stat %0d last %0d",
                                 m_axis_tdata[15:0], m_axis_tdata[31:16],
                                 m_axis_tdata[63:32], m_axis_tuser, m_axis_tlast);
                    end
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles with no handshake on either side
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("timeout with %0d words outstanding", pending_words.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    t_stim_row directed[] = '{
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 1, '{0, 0, 0, STAT_NONE_LEFT, 0}},
        '{FUNC_UNUSED, 16'h1234, 16'h5678, 32'h9, 1, '{0, 0, 0, STAT_OK, 0}},
        '{FUNC_CLEAR,  16'h0000, 16'h0000, 32'h0, 1, '{0, 0, 0, STAT_OK, 0}},
        '{FUNC_LOAD,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, '{0, 0, 0, STAT_OK, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 1,
          '{16'hFFFF, 16'hFFFF, 32'h8000_0000, STAT_OK, 1}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 1, '{0, 0, 0, STAT_NONE_LEFT, 0}},
        '{FUNC_CLEAR,  16'h0000, 16'h0000, 32'h0, 1, '{0, 0, 0, STAT_OK, 0}},
        '{FUNC_LOAD,   16'h0000, 16'h0000, 32'h0, 1, '{0, 0, 0, STAT_OK, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 1, '{0, 0, 0, STAT_ZERO_SUM, 1}},
        // loads after a sort, then a re-sort with ties and a zero value
        '{FUNC_LOAD,   16'h0001, 16'h0000, 32'h5, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_LOAD,   16'h0002, 16'h0000, 32'h0001_0000, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_LOAD,   16'h0000, 16'h0001, 32'h7, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_LOAD,   16'h0001, 16'h0000, 32'h3, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_LOAD,   16'h8000, 16'h0001, 32'h8000_0000, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
        '{FUNC_READ,   16'h0000, 16'h0000, 32'h0, 0, '{0, 0, 0, 0, 0}}
    };

    initial begin
        int n, extra, rnd_items, phase, waited;
        bit wide;
        st_count = 0; st_rpos = 0; st_sorted = 0; st_gsum = '0;
        cfg_by_rows = 0; sort_by_rows = 0;
        mismatches = 0; words_seen = 0; items_sent = 0;
        drops_seen = 0; zero_sums_seen = 0;
        idle_pct = 0; stall_pct = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table, no idling
        foreach (directed[i])
            send_word(directed[i].func, directed[i].row, directed[i].col, directed[i].val,
                      directed[i].typed, directed[i].want);

        // row grouping, then flip the mode after a sort without re-sorting
        write_by_rows(1'b1);
        send_plain(FUNC_READ, '0, '0, '0);
        write_by_rows(1'b0);
        send_plain(FUNC_READ, '0, '0, '0);
        send_plain(FUNC_LOAD, 16'h0003, 16'h0002, 32'h11);
        repeat (6) send_plain(FUNC_READ, '0, '0, '0);

        // fill the store to capacity in one column under all idling patterns,
        // overflow it, read a few
        write_by_rows(1'b0);
        send_plain(FUNC_CLEAR, '0, '0, '0);
        for (int i = 0; i <= CSGN_MAX_ENTRIES; i++) begin
            phase = (i / 256) % 4;
            idle_pct  = (phase == 1) ? 64 : (phase == 3) ? 21 : 0;
            stall_pct = (phase == 2) ? 64 : (phase == 3) ? 21 : 0;
            send_plain(FUNC_LOAD, 16'($urandom), 16'h0005, $urandom);
        end
        idle_pct = 0;
        stall_pct = 0;
        repeat (3) send_plain(FUNC_READ, '0, '0, '0);
        send_plain(FUNC_LOAD, 16'h0001, 16'h0001, 32'h1);
        send_plain(FUNC_CLEAR, '0, '0, '0);

        // random phase: mostly clear, load a matrix, read it back
        rnd_items = 0;
        waited = 0;
        while (rnd_items < RANDOM_ITEMS) begin
            phase = (rnd_items / 10) % 4;
            idle_pct  = (phase == 1) ? 64 : (phase == 3) ? 21 : 0;
            stall_pct = (phase == 2) ? 64 : (phase == 3) ? 21 : 0;
            if ($urandom_range(99) < 12) write_by_rows(1'($urandom_range(1)));
            if (!waited && rnd_items > RANDOM_ITEMS / 2) begin
                // sender holds off until every word has come back
                wait_drained();
                waited = 1;
            end
            if ($urandom_range(99) < 85) begin
                wide = ($urandom_range(3) == 0);
                n = ($urandom_range(19) == 0) ? 40 : $urandom_range(1, 12);
                send_plain(FUNC_CLEAR, '0, '0, '0);
                repeat (n) send_plain(FUNC_LOAD, pick_index(wide), pick_index(wide),
                                      pick_val());
                extra = $urandom_range(0, 2);
                if ($urandom_range(4) == 0) begin
                    // partial read, append, read everything again
                    repeat ($urandom_range(1, n)) send_plain(FUNC_READ, '0, '0, '0);
                    if ($urandom_range(1)) write_by_rows(1'($urandom_range(1)));
                    send_plain(FUNC_LOAD, pick_index(wide), pick_index(wide), pick_val());
                    n++;
                end
                repeat (n + extra) send_plain(FUNC_READ, '0, '0, '0);
                rnd_items += 2 * n + extra + 1;
            end else begin
                // noise, including the unused code
                repeat (4) begin
                    send_plain(2'($urandom), 16'($urandom), 16'($urandom), $urandom);
                end
                rnd_items += 4;
            end
        end

        idle_pct = 0;
        stall_pct = 0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);

        $display("covered %0d words in, %0d out (%0d dropped loads, %0d zero-sum reads)",
                 items_sent, words_seen, drops_seen, zero_sums_seen);
        $display("both grouping modes, full store, re-sorts and four idling patterns");
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("mismatches: %0d", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
